// ===== design/tpbp_pkg.sv =====
`default_nettype none

package tpbp_pkg;

    localparam int WORD_W              = 32;
    localparam int BLOCK_WORDS_DEFAULT = 16;

    // layout codes, two bits per word in the block mask
    typedef logic [1:0] layout_t;
    localparam layout_t LAYOUT_RAW   = 2'd0;
    localparam layout_t LAYOUT_20_12 = 2'd1;
    localparam layout_t LAYOUT_16_16 = 2'd2;
    localparam layout_t LAYOUT_12_20 = 2'd3;

    typedef enum logic [1:0] {
        SEQ_MASK,
        SEQ_DATA,
        SEQ_TAIL
    } seq_state_t;

    typedef struct packed {
        layout_t             code;
        logic [WORD_W-1:0]   word;
    } pair_t;

    // one output beat as it travels through the read stage and output queue
    typedef struct packed {
        logic                src_ram;
        logic [WORD_W-1:0]   word;
        logic                is_mask;
        logic                last;
    } out_beat_t;

    function automatic pair_t pair_pack(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b);
        pair_t p;
        priority if (a[31:16] == 16'd0 && b[31:16] == 16'd0) begin
            p.code = LAYOUT_16_16;
            p.word = a | (b << 16);
        end else if (a[31:20] == 12'd0 && b[31:12] == 20'd0) begin
            p.code = LAYOUT_20_12;
            p.word = a | (b << 20);
        end else if (a[31:12] == 20'd0 && b[31:20] == 12'd0) begin
            p.code = LAYOUT_12_20;
            p.word = a | (b << 12);
        end else begin
            p.code = LAYOUT_RAW;
            p.word = a;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/tpbp_ram.sv =====
`default_nettype none

module tpbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/token_pair_block_packer.sv =====
`default_nettype none

// Token pair block packer. Each s_ beat carries one 32-bit token (tlast marks
// the end of the stream). One token is held back and paired with the next one
// into a single word (16+16, 20+12 or 12+20 bit layouts, else the held token is
// written alone). Words fill a block of BLOCK_WORDS entries; when the block is
// full, or the stream ends, it goes out on m_ as the layout mask beat
// (tuser = 1) followed by the data beats, tlast set on the final beat caused
// by an input beat. Rate: one input beat per cycle while the bank being filled
// is free and the descriptor queue has room. The word store is one RAM
// split into two banks: one fills while the other drains through the single
// read port, one beat per cycle while m_ is not stalled; a raw end-of-stream
// token is carried beside the RAM. Input stalls only when both banks still
// await draining or the block-descriptor queue lacks two free slots; paired
// streams sustain one token per cycle, all-raw streams are bound by the
// output at 16 tokens per 17 beats for full blocks.
module token_pair_block_packer
#(
    parameter int BLOCK_WORDS = tpbp_pkg::BLOCK_WORDS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [tpbp_pkg::WORD_W-1:0] s_tdata,   // [31:0] token
    input  wire logic                        s_tlast,   // end_of_stream
    // output stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [tpbp_pkg::WORD_W-1:0] m_tdata,   // [31:0] word
    output logic                             m_tuser,   // [0] is_mask
    output logic                             m_tlast    // last
);

    import tpbp_pkg::*;

    localparam int POS_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int FILL_W     = $clog2(BLOCK_WORDS + 1);
    localparam int ADDR_W     = POS_W + 1;
    localparam int RAM_DEPTH  = 1 << ADDR_W;
    localparam int DPTR_W     = 2;
    localparam int DESC_DEPTH = 1 << DPTR_W;
    localparam int DCNT_W     = DPTR_W + 1;

    localparam logic [FILL_W-1:0] BLOCK_FULL = FILL_W'(BLOCK_WORDS);

    // closed block waiting to be drained
    typedef struct packed {
        logic                bank;
        logic [FILL_W-1:0]   count;      // words held in the RAM bank
        logic [WORD_W-1:0]   mask;
        logic                tail_valid; // raw end-of-stream token after the RAM words
        logic [WORD_W-1:0]   tail_word;
        logic                last;       // final block of its input beat
    } desc_t;

    // ---------------------------------------------------------------- front end
    logic                pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0]   pend_token_reg, pend_token_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [WORD_W-1:0]   mask_reg, mask_next;
    logic                cur_bank_reg, cur_bank_next;
    logic [1:0]          bank_busy_reg, bank_busy_next;

    logic                s_fire;
    pair_t               pair;
    logic [POS_W-1:0]    pos;
    logic [FILL_W-1:0]   fill_a;
    logic [WORD_W-1:0]   mask_a;
    logic                close1;
    logic                tail;
    logic                push0, push1;
    desc_t               desc0, desc1;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;

    // --------------------------------------------------------- descriptor queue
    desc_t               desc_mem [DESC_DEPTH];
    logic [DPTR_W-1:0]   desc_wptr_reg, desc_rptr_reg;
    logic [DPTR_W-1:0]   desc_wptr_inc;
    logic [DCNT_W-1:0]   desc_cnt_reg;
    logic [1:0]          n_push;
    desc_t               head;
    logic                head_valid;

    // ----------------------------------------------------------------- back end
    seq_state_t          seq_state_reg, seq_state_next;
    logic [FILL_W-1:0]   k_reg, k_next;
    logic                k_end;
    logic                issue, room;
    logic [1:0]          occ;
    logic                pop;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   ram_rdata;
    out_beat_t           issue_beat;

    logic                s1_valid_reg;
    out_beat_t           s1_beat_reg;
    out_beat_t           s1_resolved;

    out_beat_t           oq [2];
    logic [1:0]          oq_cnt_reg;
    logic                oq_wptr_reg, oq_rptr_reg;
    logic                m_fire;

    // ---------------------------------------------------------------- front end
    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !bank_busy_reg[cur_bank_reg] && (desc_cnt_reg <= DCNT_W'(DESC_DEPTH - 2));

    assign pair   = pair_pack(pend_token_reg, s_tdata);
    assign pos    = fill_reg[POS_W-1:0];
    assign fill_a = pend_valid_reg ? FILL_W'(fill_reg + 1'b1) : fill_reg;
    assign mask_a = pend_valid_reg
                  ? (mask_reg | (WORD_W'(pair.code) << {pos, 1'b0})) : mask_reg;
    assign close1 = pend_valid_reg && (fill_a == BLOCK_FULL);
    // token written raw at stream end: nothing held, or the pair failed
    assign tail   = s_tlast && (!pend_valid_reg || pair.code == LAYOUT_RAW);

    assign push0 = s_fire && (close1 || s_tlast);
    assign push1 = s_fire && close1 && tail;

    always_comb begin
        desc0.bank       = cur_bank_reg;
        desc0.count      = fill_a;
        desc0.mask       = mask_a;
        desc0.tail_valid = tail && !close1;
        desc0.tail_word  = s_tdata;
        desc0.last       = !(close1 && tail);

        // block just filled, raw token starts and ends a fresh block
        desc1.bank       = cur_bank_reg;
        desc1.count      = '0;
        desc1.mask       = '0;
        desc1.tail_valid = 1'b1;
        desc1.tail_word  = s_tdata;
        desc1.last       = 1'b1;
    end

    assign ram_we    = s_fire && pend_valid_reg;
    assign ram_waddr = {cur_bank_reg, pos};

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_token_next = pend_token_reg;
        fill_next       = fill_reg;
        mask_next       = mask_reg;
        cur_bank_next   = cur_bank_reg;
        bank_busy_next  = bank_busy_reg;
        if (pop && head.count != '0) begin
            bank_busy_next[head.bank] = 1'b0;
        end
        if (s_fire) begin
            if (s_tlast) begin
                pend_valid_next = 1'b0;
                pend_token_next = '0;
            end else if (pend_valid_reg && pair.code != LAYOUT_RAW) begin
                pend_valid_next = 1'b0;
                pend_token_next = '0;
            end else begin
                pend_valid_next = 1'b1;
                pend_token_next = s_tdata;
            end
            if (push0) begin
                fill_next = '0;
                mask_next = '0;
                if (fill_a != '0) begin
                    bank_busy_next[cur_bank_reg] = 1'b1;
                    cur_bank_next                = !cur_bank_reg;
                end
            end else begin
                fill_next = fill_a;
                mask_next = mask_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            fill_reg       <= '0;
            mask_reg       <= '0;
            cur_bank_reg   <= 1'b0;
            bank_busy_reg  <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            fill_reg       <= fill_next;
            mask_reg       <= mask_next;
            cur_bank_reg   <= cur_bank_next;
            bank_busy_reg  <= bank_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_token_reg <= pend_token_next;
    end

    // --------------------------------------------------------- descriptor queue
    assign desc_wptr_inc = desc_wptr_reg + 1'b1;
    assign n_push        = {1'b0, push0} + {1'b0, push1};
    assign head          = desc_mem[desc_rptr_reg];
    assign head_valid    = desc_cnt_reg != '0;

    always_ff @(posedge aclk) begin
        if (push0) begin
            desc_mem[desc_wptr_reg] <= desc0;
        end
        if (push1) begin
            desc_mem[desc_wptr_inc] <= desc1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_wptr_reg <= '0;
            desc_rptr_reg <= '0;
            desc_cnt_reg  <= '0;
        end else begin
            desc_wptr_reg <= desc_wptr_reg + DPTR_W'(n_push);
            desc_rptr_reg <= desc_rptr_reg + DPTR_W'(pop);
            desc_cnt_reg  <= desc_cnt_reg + DCNT_W'(n_push) - DCNT_W'(pop);
        end
    end

    // ------------------------------------------------------------- word store
    tpbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pair.word),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------- drain sequencer
    // room counts the beat in the read stage; a beat leaving this cycle frees a slot
    assign m_fire = m_tvalid && m_tready;
    assign occ    = oq_cnt_reg + {1'b0, s1_valid_reg};
    assign room   = (occ < 2'd2) || m_fire;
    assign issue  = head_valid && room;
    assign k_end  = (k_reg == FILL_W'(head.count - 1'b1));

    always_comb begin
        seq_state_next = seq_state_reg;
        unique case (seq_state_reg)
            SEQ_MASK: begin
                if (issue) begin
                    seq_state_next = (head.count != '0) ? SEQ_DATA : SEQ_TAIL;
                end
            end
            SEQ_DATA: begin
                if (issue && k_end) begin
                    seq_state_next = head.tail_valid ? SEQ_TAIL : SEQ_MASK;
                end
            end
            SEQ_TAIL: begin
                if (issue) begin
                    seq_state_next = SEQ_MASK;
                end
            end
            default: seq_state_next = SEQ_MASK;
        endcase
    end

    always_comb begin
        issue_beat.src_ram = 1'b0;
        issue_beat.word    = head.mask;
        issue_beat.is_mask = 1'b0;
        issue_beat.last    = 1'b0;
        rd_en              = 1'b0;
        rd_addr            = {head.bank, k_reg[POS_W-1:0]};
        pop                = 1'b0;
        k_next             = k_reg;
        unique case (seq_state_reg)
            SEQ_MASK: begin
                issue_beat.is_mask = 1'b1;
                k_next             = '0;
            end
            SEQ_DATA: begin
                issue_beat.src_ram = 1'b1;
                issue_beat.last    = head.last && !head.tail_valid && k_end;
                rd_en              = issue;
                pop                = issue && k_end && !head.tail_valid;
                if (issue) begin
                    k_next = FILL_W'(k_reg + 1'b1);
                end
            end
            SEQ_TAIL: begin
                issue_beat.word = head.tail_word;
                issue_beat.last = head.last;
                pop             = issue;
            end
            default: begin
                issue_beat.is_mask = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_state_reg <= SEQ_MASK;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            seq_state_reg <= seq_state_next;
            k_reg         <= k_next;
            s1_valid_reg  <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_beat_reg <= issue_beat;
        end
    end

    // ------------------------------------------------------------ output queue
    always_comb begin
        s1_resolved = s1_beat_reg;
        if (s1_beat_reg.src_ram) begin
            s1_resolved.word = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            oq[oq_wptr_reg] <= s1_resolved;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_cnt_reg  <= '0;
            oq_wptr_reg <= 1'b0;
            oq_rptr_reg <= 1'b0;
        end else begin
            oq_cnt_reg  <= oq_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, m_fire};
            oq_wptr_reg <= oq_wptr_reg ^ s1_valid_reg;
            oq_rptr_reg <= oq_rptr_reg ^ m_fire;
        end
    end

    assign m_tvalid = oq_cnt_reg != '0;
    assign m_tdata  = oq[oq_rptr_reg].word;
    assign m_tuser  = oq[oq_rptr_reg].is_mask;
    assign m_tlast  = oq[oq_rptr_reg].last;

`ifndef SYNTH
    // the bank being filled is never one still awaiting drain
    a_write_free_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !bank_busy_reg[cur_bank_reg])
        else $error("write into a bank awaiting drain");

    // RAM reads only touch closed blocks
    a_read_busy_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> bank_busy_reg[head.bank])
        else $error("read from a bank not closed");

    a_desc_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        desc_cnt_reg <= DCNT_W'(DESC_DEPTH))
        else $error("descriptor queue overflow");

    a_oq_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        occ <= 2'd2)
        else $error("output queue overflow");

    // stream end leaves nothing held and an empty block
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (!pend_valid_reg && fill_reg == '0))
        else $error("state not cleared after stream end");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_token_pair_block_packer.sv =====
`timescale 1ns / 1ps

module tb_token_pair_block_packer;

    import tpbp_pkg::*;

    localparam int BLOCK = BLOCK_WORDS_DEFAULT;

    // one m_ beat as the checker sees it
    typedef struct packed {
        logic [31:0] word;
        logic        is_mask;
        logic        last;
    } beat_t;

    // one line of the directed table; typed rows carry their beats by hand
    typedef struct {
        logic [31:0]     tok;
        logic            eos;
        bit              typed;
        int              n_typed;
        beat_t [2:0]     hand;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] token
    logic        s_tlast  = 1'b0;   // end_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] word
    logic        m_tuser;           // [0] is_mask
    logic        m_tlast;

    token_pair_block_packer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[token_pair_block_packer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Packing model: own copy of the held token, block and layout mask
    // ------------------------------------------------------------------
    logic [31:0] held_tok;
    logic        held_ok;
    logic [31:0] blk_words [BLOCK];
    logic [31:0] blk_mask;
    int          blk_fill;

    beat_t step_beats[$];   // beats caused by the current token
    beat_t words_due[$];    // beats still owed by the block, oldest first
    beat_t typed_beats[$];  // hand-written beats for a typed table row
    bit    typed_on;

    int mismatches = 0;

    // Try the three packed layouts in priority order; RAW leaves a alone.
    function automatic layout_t pair_layout(input logic [31:0] a, input logic [31:0] b,
                                            output logic [31:0] w);
        if (a < 32'h0001_0000 && b < 32'h0001_0000) begin
            w = a | (b << 16);
            return LAYOUT_16_16;
        end
        if (a < 32'h0010_0000 && b < 32'h0000_1000) begin
            w = a | (b << 20);
            return LAYOUT_20_12;
        end
        if (a < 32'h0000_1000 && b < 32'h0010_0000) begin
            w = a | (b << 12);
            return LAYOUT_12_20;
        end
        w = a;
        return LAYOUT_RAW;
    endfunction

    // mask beat first, then the words in fill order; empty block emits nothing
    task automatic flush_block();
        if (blk_fill == 0)
            return;
        step_beats.push_back({blk_mask, 1'b1, 1'b0});
        for (int k = 0; k < blk_fill; k++)
            step_beats.push_back({blk_words[k], 1'b0, 1'b0});
        blk_mask = '0;
        blk_fill = 0;
    endtask

    // a full block goes out at once, mid-token if need be
    task automatic add_word(input logic [31:0] w, input layout_t code);
        blk_words[blk_fill] = w;
        blk_mask = blk_mask | (32'(code) << (2 * blk_fill));
        blk_fill = blk_fill + 1;
        if (blk_fill >= BLOCK)
            flush_block();
    endtask

    // Advance the model by one accepted token; fills step_beats.
    task automatic pack_token(input logic [31:0] tok, input logic eos);
        logic [31:0] w;
        layout_t     code;
        beat_t       tail;
        step_beats.delete();
        if (held_ok) begin
            code = pair_layout(held_tok, tok, w);
            add_word(w, code);
            if (code != LAYOUT_RAW) begin
                held_ok  = 1'b0;
                held_tok = '0;
            end else begin
                held_tok = tok;
            end
        end else begin
            held_tok = tok;
            held_ok  = 1'b1;
        end
        // end of stream: leftover goes raw, block is flushed, nothing kept
        if (eos) begin
            if (held_ok)
                add_word(held_tok, LAYOUT_RAW);
            held_ok  = 1'b0;
            held_tok = '0;
            flush_block();
        end
        if (step_beats.size() > 0) begin
            tail = step_beats.pop_back();
            tail.last = 1'b1;
            step_beats.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    bit tx_quiet;

    function automatic int pick_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Called on a rising edge. Valid stays up into the next beat when the
    // drawn gap is zero, so it is never dropped and raised in one step.
    task automatic send_token(input logic [31:0] tok, input logic eos);
        int gap;
        gap = pick_wait(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tok;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // beat taken at this edge
        pack_token(tok, eos);
        if (typed_on) begin
            foreach (typed_beats[i])
                words_due.push_back(typed_beats[i]);
        end else begin
            foreach (step_beats[i])
                words_due.push_back(step_beats[i]);
        end
    endtask

    function automatic beat_t bt(input logic [31:0] w, input logic msk, input logic lst);
        return {w, msk, lst};
    endfunction

    stim_row_t rows[$];

    task automatic add_row(input logic [31:0] tok, input logic eos, input bit typed,
                           input int n, input beat_t b0, input beat_t b1, input beat_t b2);
        stim_row_t r;
        r.tok     = tok;
        r.eos     = eos;
        r.typed   = typed;
        r.n_typed = n;
        r.hand    = {b2, b1, b0};
        rows.push_back(r);
    endtask

    // token mix: kind 1 leans small (pairs), kind 2 leans wide (raw words)
    function automatic logic [31:0] draw_token(input int kind);
        int sel;
        case (kind)
            1:       sel = $urandom_range(0, 7);
            2:       sel = $urandom_range(6, 9);
            default: sel = $urandom_range(0, 9);
        endcase
        case (sel)
            0, 1: return $urandom_range(0, 32'h0000_0FFF);
            2, 3: return $urandom_range(0, 32'h0000_FFFF);
            4, 5: return $urandom_range(0, 32'h000F_FFFF);
            6, 7: begin
                case ($urandom_range(0, 7))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0FFF;
                    2:       return 32'h0000_1000;
                    3:       return 32'h0000_FFFF;
                    4:       return 32'h0001_0000;
                    5:       return 32'h000F_FFFF;
                    6:       return 32'h0010_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure, beat captured at the edge,
    // compared on the falling edge once the model has caught up
    // ------------------------------------------------------------------
    bit    rx_quiet = 1'b0;
    int    rx_wait  = 0;
    logic  rx_seen  = 1'b0;
    beat_t rx_beat;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_seen <= 1'b1;
            rx_beat <= {m_tdata, m_tuser, m_tlast};
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            rx_wait = pick_wait(rx_quiet);
            m_tready <= (rx_wait == 0);
        end else begin
            rx_seen <= 1'b0;
            if (!m_tready) begin
                if (rx_wait > 0)
                    rx_wait = rx_wait - 1;
                if (rx_wait == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        beat_t want;
        if (rx_seen) begin
            if (words_due.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected beat word=%h user=%b last=%b",
                             $realtime, rx_beat.word, rx_beat.is_mask, rx_beat.last);
                mismatches = mismatches + 1;
            end else begin
                want = words_due.pop_front();
                if (rx_beat !== want) begin
                    if (mismatches < 10)
                        $display("%0t: mismatch word exp %h got %h, user exp %b got %b, last exp %b got %b",
                                 $realtime, want.word, rx_beat.word, want.is_mask,
                                 rx_beat.is_mask, want.last, rx_beat.last);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        beat_t none;
        int    sent;
        int    kind;
        int    len;
        none     = bt(32'h0, 1'b0, 1'b0);
        held_tok = '0;
        held_ok  = 1'b0;
        blk_mask = '0;
        blk_fill = 0;
        typed_on = 1'b0;
        tx_quiet = 1'b0;

        // directed table
        // end of stream with nothing held: raw word behind an all-raw mask
        add_row(32'hFFFF_FFFF, 1'b1, 1, 2,
                bt(32'(LAYOUT_RAW), 1'b1, 1'b0), bt(32'hFFFF_FFFF, 1'b0, 1'b1), none);
        // first token of a stream is only held
        add_row(32'h0000_FFFF, 1'b0, 1, 0, none, none, none);
        add_row(32'h0000_FFFF, 1'b1, 1, 2,
                bt(32'(LAYOUT_16_16), 1'b1, 1'b0), bt(32'hFFFF_FFFF, 1'b0, 1'b1), none);
        add_row(32'h000F_FFFF, 1'b0, 1, 0, none, none, none);
        add_row(32'h0000_0FFF, 1'b1, 1, 2,
                bt(32'(LAYOUT_20_12), 1'b1, 1'b0), bt(32'hFFFF_FFFF, 1'b0, 1'b1), none);
        add_row(32'h0000_0FFF, 1'b0, 1, 0, none, none, none);
        add_row(32'h000F_FFFF, 1'b1, 1, 2,
                bt(32'(LAYOUT_12_20), 1'b1, 1'b0), bt(32'hFFFF_FFFF, 1'b0, 1'b1), none);
        // unpairable at stream end: held token alone, then the new one raw
        add_row(32'h8000_0000, 1'b0, 1, 0, none, none, none);
        add_row(32'h0000_0001, 1'b1, 1, 3, bt(32'(LAYOUT_RAW), 1'b1, 1'b0),
                bt(32'h8000_0000, 1'b0, 1'b0), bt(32'h0000_0001, 1'b0, 1'b1));
        // exact powers of two just miss every layout
        add_row(32'h0001_0000, 1'b0, 0, 0, none, none, none);
        add_row(32'h0000_1000, 1'b0, 0, 0, none, none, none);
        add_row(32'h0010_0000, 1'b1, 0, 0, none, none, none);
        // 17 unpairable tokens: block fills mid-token, then end of stream
        for (int i = 0; i < 17; i++)
            add_row((i % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF, i == 16, 0, 0,
                    none, none, none);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            typed_beats.delete();
            for (int j = 0; j < rows[r].n_typed; j++)
                typed_beats.push_back(rows[r].hand[j]);
            typed_on = rows[r].typed;
            send_token(rows[r].tok, rows[r].eos);
        end
        typed_on = 1'b0;

        // random streams, each closed by end of stream
        sent = rows.size();
        while (sent < 470) begin
            kind = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(1, 8);
                4, 5, 6:    len = $urandom_range(9, 24);
                default:    len = $urandom_range(25, 70);
            endcase
            if (len > 470 - sent)
                len = 470 - sent;
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                send_token(draw_token(kind), k == len - 1);
                sent = sent + 1;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then a short tail to catch stray beats
        while (words_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && words_due.size() == 0)
            $display("[token_pair_block_packer] OK");
        else
            $display("[token_pair_block_packer] ERROR");
        $finish;
    end

endmodule
